// ===== rtl/core/lcrf_pkg.sv =====
package lcrf_pkg;

  // transaction phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_TXPAY  = 3'd1;
  localparam logic [2:0] PH_RXHDR  = 3'd2;
  localparam logic [2:0] PH_RXDATA = 3'd3;
  localparam logic [2:0] PH_RXLRC  = 3'd4;

  // request kinds
  localparam logic [1:0] RQ_START = 2'd0;
  localparam logic [1:0] RQ_TXB   = 2'd1;
  localparam logic [1:0] RQ_RXB   = 2'd2;

  // result codes
  localparam logic [2:0] RC_OK      = 3'd0;
  localparam logic [2:0] RC_TOOLONG = 3'd1;
  localparam logic [2:0] RC_SYNC    = 3'd2;
  localparam logic [2:0] RC_STATUS  = 3'd3;
  localparam logic [2:0] RC_LRC     = 3'd4;
  localparam logic [2:0] RC_UNEXP   = 3'd5;

  localparam logic [7:0]  FRAME_HEAD  = 8'h55;
  localparam logic [7:0]  SYNC_FF     = 8'hFF;
  localparam logic [7:0]  SYNC_55     = 8'h55;
  localparam logic [15:0] STATUS_OK   = 16'h9000;
  localparam logic [15:0] MAX_PAYLOAD = 16'd2048;

  localparam int BURST_MAX = 8;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        rx_valid;
    logic [7:0]  rx_byte;
    logic        done_res;
    logic [2:0]  result_code;
    logic [15:0] device_status;
    logic [15:0] response_length;
  } res_t;

  typedef struct packed {
    logic [3:0]                 cnt;
    res_t [BURST_MAX-1:0]       ent;
  } burst_t;

  function automatic res_t mk_tx(input logic [7:0] b);
    res_t r;
    r = '0;
    r.tx_valid = 1'b1;
    r.tx_byte  = b;
    return r;
  endfunction

  function automatic res_t mk_rx(input logic [7:0] b);
    res_t r;
    r = '0;
    r.rx_valid = 1'b1;
    r.rx_byte  = b;
    return r;
  endfunction

  function automatic res_t mk_done(input logic [2:0] code, input logic [15:0] st,
                                   input logic [15:0] len);
    res_t r;
    r = '0;
    r.done_res        = 1'b1;
    r.result_code     = code;
    r.device_status   = st;
    r.response_length = len;
    return r;
  endfunction

endpackage

// ===== rtl/core/lcrf_core.sv =====
module lcrf_core
  import lcrf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  input  logic [1:0]  req_type,
  input  logic [31:0] command,
  input  logic [15:0] length,
  input  logic [7:0]  data_byte,
  input  logic        can_load,
  output burst_t      burst,
  output logic        load,
  output logic        consumed
);

  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]  lrc_r, lrc_nxt;
  logic [2:0]  hdr_idx_r, hdr_idx_nxt;
  logic        sync_ok_r, sync_ok_nxt;
  logic [15:0] status_r, status_nxt;
  logic [15:0] exp_len_r, exp_len_nxt;

  logic [7:0]  hdr_lrc;
  logic [7:0]  lrc_upd;
  logic [15:0] bl_dec;

  always_comb begin
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    lrc_nxt        = lrc_r;
    hdr_idx_nxt    = hdr_idx_r;
    sync_ok_nxt    = sync_ok_r;
    status_nxt     = status_r;
    exp_len_nxt    = exp_len_r;
    burst          = '0;
    hdr_lrc        = command[31:24] ^ command[23:16] ^ command[15:8] ^ command[7:0] ^
                     length[15:8] ^ length[7:0];
    lrc_upd        = lrc_r ^ data_byte;
    bl_dec         = bytes_left_r - 16'd1;

    case (phase_r)
      PH_IDLE: begin
        if (req_type == RQ_START) begin
          if (length > MAX_PAYLOAD) begin
            burst.cnt    = 4'd1;
            burst.ent[0] = mk_done(RC_TOOLONG, '0, '0);
          end else begin
            burst.ent[0] = mk_tx(FRAME_HEAD);
            burst.ent[1] = mk_tx(command[31:24]);
            burst.ent[2] = mk_tx(command[23:16]);
            burst.ent[3] = mk_tx(command[15:8]);
            burst.ent[4] = mk_tx(command[7:0]);
            burst.ent[5] = mk_tx(length[15:8]);
            burst.ent[6] = mk_tx(length[7:0]);
            if (length == '0) begin
              // empty payload: lrc right behind the header
              burst.cnt    = 4'd8;
              burst.ent[7] = mk_tx(~hdr_lrc);
              phase_nxt    = PH_RXHDR;
              hdr_idx_nxt  = '0;
              sync_ok_nxt  = 1'b1;
              lrc_nxt      = '0;
              status_nxt   = '0;
              exp_len_nxt  = '0;
            end else begin
              burst.cnt      = 4'd7;
              lrc_nxt        = hdr_lrc;
              bytes_left_nxt = length;
              phase_nxt      = PH_TXPAY;
            end
          end
        end else begin
          burst.cnt    = 4'd1;
          burst.ent[0] = mk_done(RC_UNEXP, '0, '0);
        end
      end
      PH_TXPAY: begin
        if (req_type == RQ_TXB) begin
          burst.ent[0]   = mk_tx(data_byte);
          lrc_nxt        = lrc_upd;
          bytes_left_nxt = bl_dec;
          if (bl_dec == '0) begin
            burst.cnt    = 4'd2;
            burst.ent[1] = mk_tx(~lrc_upd);
            phase_nxt    = PH_RXHDR;
            hdr_idx_nxt  = '0;
            sync_ok_nxt  = 1'b1;
            lrc_nxt      = '0;
            status_nxt   = '0;
            exp_len_nxt  = '0;
          end else begin
            burst.cnt = 4'd1;
          end
        end else begin
          burst.cnt    = 4'd1;
          burst.ent[0] = mk_done(RC_UNEXP, '0, '0);
          phase_nxt    = PH_IDLE;
        end
      end
      PH_RXHDR: begin
        if (req_type == RQ_RXB) begin
          case (hdr_idx_r)
            3'd0, 3'd1: begin
              if (data_byte != SYNC_FF) sync_ok_nxt = 1'b0;
            end
            3'd2: begin
              if (data_byte != SYNC_55) sync_ok_nxt = 1'b0;
            end
            3'd3, 3'd4: begin
              lrc_nxt    = lrc_upd;
              status_nxt = {status_r[7:0], data_byte};
            end
            default: begin
              lrc_nxt     = lrc_upd;
              exp_len_nxt = {exp_len_r[7:0], data_byte};
            end
          endcase
          if (hdr_idx_r >= 3'd6) begin
            hdr_idx_nxt = '0;
            if (!sync_ok_nxt) begin
              burst.cnt    = 4'd1;
              burst.ent[0] = mk_done(RC_SYNC, '0, '0);
              phase_nxt    = PH_IDLE;
            end else if (status_nxt != STATUS_OK) begin
              burst.cnt    = 4'd1;
              burst.ent[0] = mk_done(RC_STATUS, status_nxt, '0);
              phase_nxt    = PH_IDLE;
            end else if (exp_len_nxt == '0) begin
              phase_nxt = PH_RXLRC;
            end else begin
              bytes_left_nxt = exp_len_nxt;
              phase_nxt      = PH_RXDATA;
            end
          end else begin
            hdr_idx_nxt = hdr_idx_r + 3'd1;
          end
        end else begin
          burst.cnt    = 4'd1;
          burst.ent[0] = mk_done(RC_UNEXP, '0, '0);
          phase_nxt    = PH_IDLE;
        end
      end
      PH_RXDATA: begin
        if (req_type == RQ_RXB) begin
          burst.cnt      = 4'd1;
          burst.ent[0]   = mk_rx(data_byte);
          lrc_nxt        = lrc_upd;
          bytes_left_nxt = bl_dec;
          if (bl_dec == '0) phase_nxt = PH_RXLRC;
        end else begin
          burst.cnt    = 4'd1;
          burst.ent[0] = mk_done(RC_UNEXP, '0, '0);
          phase_nxt    = PH_IDLE;
        end
      end
      PH_RXLRC: begin
        burst.cnt = 4'd1;
        phase_nxt = PH_IDLE;
        if (req_type == RQ_RXB) begin
          if (~lrc_r == data_byte) begin
            burst.ent[0] = mk_done(RC_OK, status_r, exp_len_r);
          end else begin
            burst.ent[0] = mk_done(RC_LRC, status_r, '0);
          end
        end else begin
          burst.ent[0] = mk_done(RC_UNEXP, '0, '0);
        end
      end
      default: begin
        // unused phase codes answer any word with an unexpected result and return to idle
        burst.cnt    = 4'd1;
        burst.ent[0] = mk_done(RC_UNEXP, '0, '0);
        phase_nxt    = PH_IDLE;
      end
    endcase
  end

  assign load     = item_valid && (burst.cnt != '0) && can_load;
  assign consumed = item_valid && ((burst.cnt == '0) || can_load);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bytes_left_r <= '0;
      lrc_r        <= '0;
      hdr_idx_r    <= '0;
      sync_ok_r    <= 1'b1;
      status_r     <= '0;
      exp_len_r    <= '0;
    end else if (consumed) begin
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      lrc_r        <= lrc_nxt;
      hdr_idx_r    <= hdr_idx_nxt;
      sync_ok_r    <= sync_ok_nxt;
      status_r     <= status_nxt;
      exp_len_r    <= exp_len_nxt;
    end
  end

  a_hdr_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_idx_r <= 3'd6)
    else $error("header index ran past the seven-byte header");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_TXPAY || phase_r == PH_RXDATA) |-> bytes_left_r != '0)
    else $error("data phase entered with nothing left to move");

  a_zero_burst_only_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && burst.cnt == '0) |-> (phase_r == PH_RXHDR || phase_r == PH_RXDATA))
    else $error("silent item outside the response header");

endmodule

// ===== rtl/core/lcrf_emitter.sv =====
module lcrf_emitter
  import lcrf_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   load,
  input  burst_t burst,
  output logic   can_load,
  output logic   out_valid,
  input  logic   out_ready,
  output res_t   out_res,
  output logic   out_last
);

  res_t [BURST_MAX-1:0] buf_r;
  logic                 busy_r;
  logic [2:0]           idx_r;
  logic [2:0]           top_r;
  logic                 fire;
  logic                 at_end;

  assign fire      = busy_r && out_ready;
  assign at_end    = (idx_r == top_r);
  assign can_load  = !busy_r || (out_ready && at_end);
  assign out_valid = busy_r;
  assign out_res   = buf_r[idx_r];
  assign out_last  = at_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      top_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
      top_r  <= 3'(burst.cnt - 4'd1);
    end else if (fire) begin
      if (at_end) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= burst.ent;
    end
  end

  a_idx_le_top: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r <= top_r)
    else $error("burst index beyond its count");

  a_drain_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && at_end && !load) |=> !busy_r)
    else $error("burst kept running after its last word");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !out_ready) |=> (busy_r && $stable(idx_r)))
    else $error("burst moved while the sink stalled");

endmodule

// ===== rtl/core/lrc_command_response_framer.sv =====
// a request word passes the input register, then its first result word the emitter's burst register
// throughput: one result word per cycle while out_tready is high; a start word takes 7 or 8
//   result words (1 if too long), a payload word 1 or 2, a response word 0 or 1, a stray word 1
// a new input word is taken while the last word of the previous burst leaves
// reset: synchronous active-low rst_n clears phase, counters, lrc and handshake

module lrc_command_response_framer
  import lcrf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // command[31:0], length[47:32], data_byte[55:48]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // tx_byte[7:0], rx_byte[15:8], result_code[18:16],
                                  // device_status[34:19], response_length[50:35], zero
  output logic [2:0]  out_tuser,  // tx_valid[0], rx_valid[1], done_res[2]
  output logic        out_tlast   // last result word of the request word
);

  // input register
  logic        hold_v_r;
  logic [1:0]  req_type_r;
  logic [31:0] command_r;
  logic [15:0] length_r;
  logic [7:0]  data_byte_r;

  logic   consumed;
  logic   load;
  logic   can_load;
  burst_t burst;
  res_t   res;

  // the held word leaves whenever its burst can load (or it makes none)
  assign in_tready = !hold_v_r || consumed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (in_tready) begin
      hold_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      req_type_r  <= in_tuser;
      command_r   <= in_tdata[31:0];
      length_r    <= in_tdata[47:32];
      data_byte_r <= in_tdata[55:48];
    end
  end

  // framing and parsing step
  lcrf_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(hold_v_r),
    .req_type  (req_type_r),
    .command   (command_r),
    .length    (length_r),
    .data_byte (data_byte_r),
    .can_load  (can_load),
    .burst     (burst),
    .load      (load),
    .consumed  (consumed)
  );

  // result burst register, one word per cycle while the sink is ready
  lcrf_emitter u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .burst    (burst),
    .can_load (can_load),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (res),
    .out_last (out_tlast)
  );

  assign out_tdata = {5'd0, res.response_length, res.device_status, res.result_code,
                      res.rx_byte, res.tx_byte};
  assign out_tuser = {res.done_res, res.rx_valid, res.tx_valid};

endmodule

// ===== bench/tb_lrc_command_response_framer.sv =====
module tb_lrc_command_response_framer;
  timeunit 1ns;
  timeprecision 1ps;

  import lcrf_pkg::*;

  // request kind that no phase accepts
  localparam logic [1:0] RQ_BAD = 2'd3;
  // watchdog, far above the slowest legal run
  localparam int CYCLE_LIMIT = 400000;
  // random words are added until the queue, directed part included, holds this many request words
  localparam int REQ_TARGET = 112;

  // one request word as the sender holds it
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] cmd;
    logic [15:0] len;
    logic [7:0]  dbyte;
    logic        hold;   // wait for every due result before offering this word
  } request_t;

  // one result word, unpacked from the output bus
  typedef struct packed {
    logic        txv;
    logic [7:0]  txb;
    logic        rxv;
    logic [7:0]  rxb;
    logic        done;
    logic [2:0]  code;
    logic [15:0] st;
    logic [15:0] rlen;
    logic        lst;
  } link_word_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  lrc_command_response_framer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // request words waiting for the driver
  request_t   requests_q[$];
  // result words the framer owes, oldest first
  link_word_t link_words_due[$];
  int         n_bad = 0;
  int         cycles = 0;

  // framer state mirror, at its reset values
  logic [2:0]  fr_phase  = PH_IDLE;
  logic [15:0] fr_left   = '0;
  logic [7:0]  fr_lrc    = '0;
  logic [2:0]  hdr_idx   = '0;
  logic        sync_ok   = 1'b1;
  logic [15:0] stat_word = '0;
  logic [15:0] resp_len  = '0;

  // result words of the request word being worked out
  link_word_t step_words[8];
  int         step_n;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // framer prediction
  // -------------------------------------------------------------------------

  task automatic add_tx(input logic [7:0] b);
    step_words[step_n] = '0;
    step_words[step_n].txv = 1'b1;
    step_words[step_n].txb = b;
    step_n++;
  endtask

  task automatic add_rx(input logic [7:0] b);
    step_words[step_n] = '0;
    step_words[step_n].rxv = 1'b1;
    step_words[step_n].rxb = b;
    step_n++;
  endtask

  // a done word always closes the transaction
  task automatic add_done(input logic [2:0] code, input logic [15:0] st,
                          input logic [15:0] rlen);
    step_words[step_n] = '0;
    step_words[step_n].done = 1'b1;
    step_words[step_n].code = code;
    step_words[step_n].st   = st;
    step_words[step_n].rlen = rlen;
    step_n++;
    fr_phase = PH_IDLE;
  endtask

  // outgoing frame complete, reply parsing starts fresh
  task automatic open_reply();
    fr_phase  = PH_RXHDR;
    hdr_idx   = '0;
    sync_ok   = 1'b1;
    fr_lrc    = '0;
    stat_word = '0;
    resp_len  = '0;
  endtask

  task automatic advance_framer(input request_t rq);
    logic [47:0] head6;
    logic [7:0]  b;
    logic [2:0]  hi;
    int          i;
    step_n = 0;
    b = rq.dbyte;
    if (fr_phase == PH_IDLE && rq.kind == RQ_START) begin
      if (rq.len > MAX_PAYLOAD) begin
        add_done(RC_TOOLONG, '0, '0);
      end else begin
        // 0x55, command big-endian, length big-endian
        head6 = {rq.cmd, rq.len};
        add_tx(FRAME_HEAD);
        fr_lrc = '0;
        for (i = 0; i < 6; i++) begin
          add_tx(head6[47 - 8*i -: 8]);
          fr_lrc ^= head6[47 - 8*i -: 8];
        end
        if (rq.len == 0) begin
          add_tx(~fr_lrc);
          open_reply();
        end else begin
          fr_left  = rq.len;
          fr_phase = PH_TXPAY;
        end
      end
    end else if (fr_phase == PH_TXPAY && rq.kind == RQ_TXB) begin
      add_tx(b);
      fr_lrc ^= b;
      fr_left = fr_left - 16'd1;
      if (fr_left == 0) begin
        add_tx(~fr_lrc);
        open_reply();
      end
    end else if (fr_phase == PH_RXHDR && rq.kind == RQ_RXB) begin
      hi = hdr_idx;
      if (hi == 0 || hi == 1) begin
        if (b != SYNC_FF) sync_ok = 1'b0;
      end else if (hi == 2) begin
        if (b != SYNC_55) sync_ok = 1'b0;
      end else begin
        // status and length bytes feed the reply lrc
        fr_lrc ^= b;
        if (hi < 5) stat_word = {stat_word[7:0], b};
        else resp_len = {resp_len[7:0], b};
      end
      if (hi >= 6) begin
        hdr_idx = '0;
        if (!sync_ok) begin
          add_done(RC_SYNC, '0, '0);
        end else if (stat_word != STATUS_OK) begin
          add_done(RC_STATUS, stat_word, '0);
        end else if (resp_len == 0) begin
          fr_phase = PH_RXLRC;
        end else begin
          fr_left  = resp_len;
          fr_phase = PH_RXDATA;
        end
      end else begin
        hdr_idx = hi + 3'd1;
      end
    end else if (fr_phase == PH_RXDATA && rq.kind == RQ_RXB) begin
      add_rx(b);
      fr_lrc ^= b;
      fr_left = fr_left - 16'd1;
      if (fr_left == 0) fr_phase = PH_RXLRC;
    end else if (fr_phase == PH_RXLRC && rq.kind == RQ_RXB) begin
      if ((fr_lrc ^ b) == 8'hFF) add_done(RC_OK, stat_word, resp_len);
      else add_done(RC_LRC, stat_word, '0);
    end else begin
      add_done(RC_UNEXP, '0, '0);
    end
    if (step_n > 0) step_words[step_n-1].lst = 1'b1;
    for (i = 0; i < step_n; i++) link_words_due.push_back(step_words[i]);
  endtask

  // -------------------------------------------------------------------------
  // stimulus building
  // -------------------------------------------------------------------------

  // non-start word, command and length fields are don't-care noise
  function automatic request_t mk_req(input logic [1:0] kind, input logic [7:0] b);
    request_t r;
    r.kind  = kind;
    r.cmd   = $urandom;
    r.len   = 16'($urandom);
    r.dbyte = b;
    r.hold  = 1'b0;
    return r;
  endfunction

  function automatic request_t mk_start(input logic [31:0] cmd, input logic [15:0] len,
                                       input logic hold);
    request_t r;
    r.kind  = RQ_START;
    r.cmd   = cmd;
    r.len   = len;
    r.dbyte = 8'($urandom);
    r.hold  = hold;
    return r;
  endfunction

  // one full exchange: request frame, then the device reply, maybe damaged
  task automatic add_exchange();
    request_t    seq[$];
    logic [7:0]  sync_b[3];
    logic [7:0]  lrc;
    logic [7:0]  b;
    logic [15:0] st;
    logic [15:0] rl;
    int          plen;
    int          flaw;
    int          i;
    int          cut;
    plen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 4);
    seq.push_back(mk_start($urandom, 16'(plen), $urandom_range(0, 3) == 0));
    for (i = 0; i < plen; i++) seq.push_back(mk_req(RQ_TXB, 8'($urandom)));
    // flaw: 0 bad sync, 1 bad status, 2 bad lrc, 3 cut short by a stray word
    flaw = $urandom_range(0, 9);
    sync_b[0] = SYNC_FF;
    sync_b[1] = SYNC_FF;
    sync_b[2] = SYNC_55;
    if (flaw == 0) sync_b[$urandom_range(0, 2)] ^= 8'($urandom_range(1, 255));
    st = (flaw == 1) ? 16'($urandom) : STATUS_OK;
    rl = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 20)) : 16'($urandom_range(0, 4));
    for (i = 0; i < 3; i++) seq.push_back(mk_req(RQ_RXB, sync_b[i]));
    seq.push_back(mk_req(RQ_RXB, st[15:8]));
    seq.push_back(mk_req(RQ_RXB, st[7:0]));
    seq.push_back(mk_req(RQ_RXB, rl[15:8]));
    seq.push_back(mk_req(RQ_RXB, rl[7:0]));
    if (flaw != 0 && st == STATUS_OK) begin
      lrc = st[15:8] ^ st[7:0] ^ rl[15:8] ^ rl[7:0];
      for (i = 0; i < rl; i++) begin
        b = 8'($urandom);
        lrc ^= b;
        seq.push_back(mk_req(RQ_RXB, b));
      end
      lrc = ~lrc;
      if (flaw == 2) lrc ^= 8'($urandom_range(1, 255));
      seq.push_back(mk_req(RQ_RXB, lrc));
    end
    if (flaw == 3) begin
      cut = $urandom_range(1, seq.size() - 1);
      while (seq.size() > cut) void'(seq.pop_back());
      seq.push_back(mk_req(2'($urandom_range(0, 3)), 8'($urandom)));
      seq[seq.size()-1].len = 16'($urandom);
    end
    foreach (seq[i]) requests_q.push_back(seq[i]);
  endtask

  // -------------------------------------------------------------------------
  // request driver
  // -------------------------------------------------------------------------

  request_t on_bus;
  int       in_gap = 0;
  bit       in_calm = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      // word taken this edge, account for it before choosing the next
      if (in_tvalid && in_tready) advance_framer(on_bus);
      if (!in_tvalid || in_tready) begin
        if (in_gap != 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (requests_q.size() != 0 &&
                     !(requests_q[0].hold && link_words_due.size() != 0)) begin
          on_bus = requests_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {on_bus.dbyte, on_bus.len, on_bus.cmd};
          in_tuser  <= on_bus.kind;
          // idle stretches alternate with back-to-back runs
          if ($urandom_range(0, 19) == 0) in_calm = !in_calm;
          in_gap = in_calm ? 0 : $urandom_range(0, 16);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // result monitor
  // -------------------------------------------------------------------------

  int out_stall = 0;
  bit out_calm = 1'b0;

  task automatic note_field(input string fname, input logic [15:0] want,
                            input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %h got %h", $time, fname, want, got);
      n_bad++;
    end
  endtask

  task automatic check_word();
    link_word_t got;
    link_word_t want;
    got.txb  = out_tdata[7:0];
    got.rxb  = out_tdata[15:8];
    got.code = out_tdata[18:16];
    got.st   = out_tdata[34:19];
    got.rlen = out_tdata[50:35];
    got.txv  = out_tuser[0];
    got.rxv  = out_tuser[1];
    got.done = out_tuser[2];
    got.lst  = out_tlast;
    if (link_words_due.size() == 0) begin
      $display("%0t ns: result word with none due, expected nothing got %h", $time, got);
      n_bad++;
    end else begin
      want = link_words_due.pop_front();
      note_field("tx_valid",        16'(want.txv),  16'(got.txv));
      note_field("tx_byte",         16'(want.txb),  16'(got.txb));
      note_field("rx_valid",        16'(want.rxv),  16'(got.rxv));
      note_field("rx_byte",         16'(want.rxb),  16'(got.rxb));
      note_field("done_res",        16'(want.done), 16'(got.done));
      note_field("result_code",     16'(want.code), 16'(got.code));
      note_field("device_status",   want.st,        got.st);
      note_field("response_length", want.rlen,      got.rlen);
      note_field("last",            16'(want.lst),  16'(got.lst));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_word();
        if ($urandom_range(0, 19) == 0) out_calm = !out_calm;
        out_stall = out_calm ? 0 : $urandom_range(0, 16);
      end
      if (out_stall != 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // sequence
  // -------------------------------------------------------------------------

  initial begin
    // directed: length bounds, stray words while idle and in the payload, empty payload
    // and empty reply, a short payload, a start while busy
    requests_q.push_back(mk_start(32'h0123_4567, 16'd2049, 1'b0));
    requests_q.push_back(mk_start(32'hA5A5_5A5A, MAX_PAYLOAD, 1'b0));
    requests_q.push_back(mk_req(RQ_RXB, 8'h00));
    requests_q.push_back(mk_start(32'h0000_0000, 16'hFFFF, 1'b0));
    requests_q.push_back(mk_req(RQ_RXB, 8'hFF));
    requests_q.push_back(mk_req(RQ_TXB, 8'h00));
    requests_q.push_back(mk_req(RQ_BAD, 8'hFF));
    requests_q.push_back(mk_start(32'hFFFF_FFFF, 16'd0, 1'b0));
    requests_q.push_back(mk_req(RQ_RXB, SYNC_FF));
    requests_q.push_back(mk_req(RQ_RXB, SYNC_FF));
    requests_q.push_back(mk_req(RQ_RXB, SYNC_55));
    requests_q.push_back(mk_req(RQ_RXB, STATUS_OK[15:8]));
    requests_q.push_back(mk_req(RQ_RXB, STATUS_OK[7:0]));
    requests_q.push_back(mk_req(RQ_RXB, 8'h00));
    requests_q.push_back(mk_req(RQ_RXB, 8'h00));
    // empty reply, lrc covers status and length only
    requests_q.push_back(mk_req(RQ_RXB, ~(STATUS_OK[15:8] ^ STATUS_OK[7:0])));
    // sender holds off here until the reply result has drained
    requests_q.push_back(mk_start(32'h0000_0000, 16'd2, 1'b1));
    requests_q.push_back(mk_req(RQ_TXB, 8'h00));
    requests_q.push_back(mk_req(RQ_TXB, 8'hFF));
    requests_q.push_back(mk_start(32'hDEAD_BEEF, 16'd1, 1'b0));

    // random: mostly well-formed exchanges, some stray words
    while (requests_q.size() < REQ_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        requests_q.push_back(mk_req(2'($urandom_range(0, 3)), 8'($urandom)));
        requests_q[requests_q.size()-1].len = 16'($urandom);
      end else begin
        add_exchange();
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // drain: sender empty, then every due result word back
    // sampled mid-cycle so the driver's updates of this edge are settled
    while (requests_q.size() != 0 || in_tvalid) @(negedge clk);
    while (link_words_due.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);

    if (n_bad == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
